// ===== rtl/rtch_pkg.sv =====
package rtch_pkg;

   localparam int COORD_BITS_DEF    = 24;
   localparam int DIR_FRAC_BITS_DEF = 14;
   localparam int EPS_DET_DEF       = 0;

   // configuration register indexes
   localparam logic [2:0] CSR_ORG_X = 3'd0;
   localparam logic [2:0] CSR_ORG_Y = 3'd1;
   localparam logic [2:0] CSR_ORG_Z = 3'd2;
   localparam logic [2:0] CSR_DIR_X = 3'd3;
   localparam logic [2:0] CSR_DIR_Y = 3'd4;
   localparam logic [2:0] CSR_DIR_Z = 3'd5;

   localparam logic [4:0] LAST_STEP = 5'd23;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_ACC, ST_NORM, ST_CHECK, ST_DIV, ST_DONE
   } state_type;

   // narrow multiplier operand sources
   typedef enum logic [3:0] {
      N_D0, N_D1, N_D2, N_E1_0, N_E1_1, N_E1_2,
      N_E2_0, N_E2_1, N_E2_2, N_T0, N_T1, N_T2
   } nsrc_type;

   // wide multiplier operand sources
   typedef enum logic [3:0] {
      W_E1_0, W_E1_1, W_E1_2, W_E2_0, W_E2_1, W_E2_2,
      W_P0, W_P1, W_P2, W_Q0, W_Q1, W_Q2
   } wsrc_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
      DST_DET, DST_UN, DST_VN, DST_TN
   } dest_type;

   typedef struct packed {
      nsrc_type nsel;
      wsrc_type wsel;
      logic     sub;
      logic     first;
      dest_type dest;
   } op_type;

   typedef struct packed {
      logic done;
      logic neg;
   } mac_stat_type;

   // microprogram: one multiply-accumulate term per step
   function automatic op_type op_of(input logic [4:0] step);
      op_type op;
      op = '{nsel: N_D0, wsel: W_E1_0, sub: 1'b0, first: 1'b0, dest: DST_NONE};
      case (step)
         5'd0:  op = '{N_D1,   W_E2_2, 1'b0, 1'b1, DST_NONE};
         5'd1:  op = '{N_D2,   W_E2_1, 1'b1, 1'b0, DST_P0};
         5'd2:  op = '{N_D2,   W_E2_0, 1'b0, 1'b1, DST_NONE};
         5'd3:  op = '{N_D0,   W_E2_2, 1'b1, 1'b0, DST_P1};
         5'd4:  op = '{N_D0,   W_E2_1, 1'b0, 1'b1, DST_NONE};
         5'd5:  op = '{N_D1,   W_E2_0, 1'b1, 1'b0, DST_P2};
         5'd6:  op = '{N_T1,   W_E1_2, 1'b0, 1'b1, DST_NONE};
         5'd7:  op = '{N_T2,   W_E1_1, 1'b1, 1'b0, DST_Q0};
         5'd8:  op = '{N_T2,   W_E1_0, 1'b0, 1'b1, DST_NONE};
         5'd9:  op = '{N_T0,   W_E1_2, 1'b1, 1'b0, DST_Q1};
         5'd10: op = '{N_T0,   W_E1_1, 1'b0, 1'b1, DST_NONE};
         5'd11: op = '{N_T1,   W_E1_0, 1'b1, 1'b0, DST_Q2};
         5'd12: op = '{N_E1_0, W_P0,   1'b0, 1'b1, DST_NONE};
         5'd13: op = '{N_E1_1, W_P1,   1'b0, 1'b0, DST_NONE};
         5'd14: op = '{N_E1_2, W_P2,   1'b0, 1'b0, DST_DET};
         5'd15: op = '{N_T0,   W_P0,   1'b0, 1'b1, DST_NONE};
         5'd16: op = '{N_T1,   W_P1,   1'b0, 1'b0, DST_NONE};
         5'd17: op = '{N_T2,   W_P2,   1'b0, 1'b0, DST_UN};
         5'd18: op = '{N_D0,   W_Q0,   1'b0, 1'b1, DST_NONE};
         5'd19: op = '{N_D1,   W_Q1,   1'b0, 1'b0, DST_NONE};
         5'd20: op = '{N_D2,   W_Q2,   1'b0, 1'b0, DST_VN};
         5'd21: op = '{N_E2_0, W_Q0,   1'b0, 1'b1, DST_NONE};
         5'd22: op = '{N_E2_1, W_Q1,   1'b0, 1'b0, DST_NONE};
         5'd23: op = '{N_E2_2, W_Q2,   1'b0, 1'b0, DST_TN};
         default: op = '{N_D0, W_E1_0, 1'b0, 1'b0, DST_NONE};
      endcase
      return op;
   endfunction

endpackage

// ===== rtl/rtch_mac.sv =====
// shift-add multiplier, one bit of the narrow operand per cycle
module rtch_mac #(
   parameter int NW = 25,
   parameter int WW = 51
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NW-1:0]    a_in,
   input  logic signed [WW-1:0]    b_in,
   input  logic                    sub,
   output logic [NW+WW-1:0]        mag,
   output rtch_pkg::mac_stat_type  stat
);
   localparam int MW = NW + WW;
   localparam int CNW = (NW > 1) ? $clog2(NW) : 1;

   logic [NW-1:0]  a_sr_ff, a_sr_in;
   logic [MW-1:0]  b_sh_ff, b_sh_in;
   logic [MW-1:0]  mag_ff, mag_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           neg_ff, neg_in;
   logic [NW-1:0]  a_abs;
   logic [WW-1:0]  b_abs;

   always_comb begin
      a_abs   = a_in[NW-1] ? (~a_in + 1'b1) : a_in;
      b_abs   = b_in[WW-1] ? (~b_in + 1'b1) : b_in;
      a_sr_in = a_sr_ff;
      b_sh_in = b_sh_ff;
      mag_in  = mag_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         a_sr_in = a_abs;
         b_sh_in = MW'(b_abs);
         mag_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = a_in[NW-1] ^ b_in[WW-1] ^ sub;
      end else if (busy_ff) begin
         if (a_sr_ff[0]) begin
            mag_in = mag_ff + b_sh_ff;
         end
         a_sr_in = a_sr_ff >> 1;
         b_sh_in = b_sh_ff << 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_sr_ff <= a_sr_in;
      b_sh_ff <= b_sh_in;
      mag_ff  <= mag_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   assign mag       = mag_ff;
   assign stat.done = done_ff;
   assign stat.neg  = neg_ff;

endmodule

// ===== rtl/rtch_div.sv =====
// restoring divider, one quotient bit per cycle, saturating distance
module rtch_div #(
   parameter int COORD_BITS    = rtch_pkg::COORD_BITS_DEF,
   parameter int DIR_FRAC_BITS = rtch_pkg::DIR_FRAC_BITS_DEF,
   parameter int AW            = 80
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [AW-1:0]         num,
   input  logic [AW-1:0]         den,
   output logic                  done,
   output logic [COORD_BITS-2:0] quo
);
   localparam int CB  = COORD_BITS;
   localparam int DVW = AW + rtch_pkg::imax(DIR_FRAC_BITS, CB - 1);
   localparam int CNW = $clog2(CB);

   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dsh_ff, dsh_in;
   logic [CB-1:0]  q_ff, q_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DVW'(num) << DIR_FRAC_BITS;
         dsh_in  = DVW'(den) << (CB - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[CB-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[CB-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(CB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   // top quotient bit set means the distance is past full scale
   assign done = done_ff;
   assign quo  = q_ff[CB-1] ? '1 : q_ff[CB-2:0];

endmodule

// ===== rtl/ray_triangle_closest_hit_unit.sv =====
// Moller-Trumbore ray/triangle test with running closest hit. Ray origin
// (Q15.8) and unit direction (Q1.14) are to be set through the csr_ write
// port only while the unit is idle; the unit itself does not enforce this.
// Each req_ beat carries one triangle and yields one rsp_ beat with this
// triangle's hit and distance plus the nearest hit so far; the nearest hit
// clears after the beat marked with tlast. All arithmetic is exact: one
// shared shift-add multiplier evaluates the 24 product terms of the two
// cross products and four dot products, one narrow-operand bit per cycle,
// then a restoring divider produces the Q15.8 distance one bit per cycle,
// saturating at full scale. A miss found before the divide skips it. The
// unit takes no new triangle until the previous one is finished; a finished
// result waits in the output register while the next triangle computes.
module ray_triangle_closest_hit_unit #(
   parameter int COORD_BITS    = rtch_pkg::COORD_BITS_DEF,
   parameter int DIR_FRAC_BITS = rtch_pkg::DIR_FRAC_BITS_DEF,
   parameter int EPS_DET       = rtch_pkg::EPS_DET_DEF,
   localparam int CW_L   = rtch_pkg::imax(COORD_BITS, DIR_FRAC_BITS + 2),
   localparam int INW_L  = ((9 * COORD_BITS + 7) / 8) * 8,
   localparam int OUTW_L = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // triangle beats
   input  logic              req_tvalid,
   output logic              req_tready,
   // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z, COORD_BITS each
   input  logic [INW_L-1:0]  req_tdata,
   input  logic              req_tlast,    // last_triangle
   // result beats
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tri_hit, tri_distance, nearest_found, nearest_distance
   output logic [OUTW_L-1:0] rsp_tdata,
   output logic              rsp_tlast,    // list_done
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [CW_L-1:0]   csr_data
);
   localparam int CB = COORD_BITS;
   localparam int F  = DIR_FRAC_BITS;
   localparam int DB = F + 2;
   localparam int EW = CB + 1;
   localparam int NW = rtch_pkg::imax(EW, DB);
   localparam int WW = rtch_pkg::imax(DB + EW + 1, 2 * EW + 1);
   localparam int MW = NW + WW;
   localparam int AW = MW + 2;
   localparam int DW = CB - 1;

   rtch_pkg::state_type state_ff, state_in;

   // ray registers
   logic signed [CB-1:0] org_ff [3];
   logic signed [DB-1:0] dir_ff [3];

   // per-triangle operands and results
   logic signed [EW-1:0] e1_ff [3], e1_in [3];
   logic signed [EW-1:0] e2_ff [3], e2_in [3];
   logic signed [EW-1:0] t_ff [3], t_in [3];
   logic signed [WW-1:0] p_ff [3], p_in [3];
   logic signed [WW-1:0] q_ff [3], q_in [3];
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] det_ff, det_in;
   logic [AW-1:0] un_ff, un_in;
   logic [AW-1:0] vn_ff, vn_in;
   logic [AW-1:0] tn_ff, tn_in;
   logic [4:0]    step_ff, step_in;
   logic          last_ff, last_in;
   logic [DW-1:0] dist_ff, dist_in;

   logic [DW-1:0] best_dist_ff, best_dist_in;
   logic          best_valid_ff, best_valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUTW_L-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic signed [NW-1:0] nar [12];
   logic signed [WW-1:0] wid [12];
   rtch_pkg::op_type       op;
   rtch_pkg::mac_stat_type mac_stat;
   logic [MW-1:0]          mac_mag;
   logic                   mac_start;
   logic                   div_start;
   logic                   div_done;
   logic [DW-1:0]          div_quo;
   logic                   rsp_load;
   logic                   hit_ok;
   logic [AW-1:0]          sum;
   logic                   upd;
   logic [DW-1:0]          near_dist;
   logic                   near_valid;
   logic                   tri_hit;
   logic signed [CB-1:0]   va [3], vb [3], vc [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= DB'(1) << F;
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            rtch_pkg::CSR_ORG_X: org_ff[0] <= csr_data[CB-1:0];
            rtch_pkg::CSR_ORG_Y: org_ff[1] <= csr_data[CB-1:0];
            rtch_pkg::CSR_ORG_Z: org_ff[2] <= csr_data[CB-1:0];
            rtch_pkg::CSR_DIR_X: dir_ff[0] <= csr_data[DB-1:0];
            rtch_pkg::CSR_DIR_Y: dir_ff[1] <= csr_data[DB-1:0];
            rtch_pkg::CSR_DIR_Z: dir_ff[2] <= csr_data[DB-1:0];
            default: ;
         endcase
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         va[k]      = req_tdata[k*CB +: CB];
         vb[k]      = req_tdata[(3+k)*CB +: CB];
         vc[k]      = req_tdata[(6+k)*CB +: CB];
         nar[k]     = NW'(dir_ff[k]);
         nar[3+k]   = NW'(e1_ff[k]);
         nar[6+k]   = NW'(e2_ff[k]);
         nar[9+k]   = NW'(t_ff[k]);
         wid[k]     = WW'(e1_ff[k]);
         wid[3+k]   = WW'(e2_ff[k]);
         wid[6+k]   = p_ff[k];
         wid[9+k]   = q_ff[k];
      end
   end

   assign op = rtch_pkg::op_of(step_ff);

   rtch_mac #(.NW(NW), .WW(WW)) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .a_in  (nar[op.nsel]),
      .b_in  (wid[op.wsel]),
      .sub   (op.sub),
      .mag   (mac_mag),
      .stat  (mac_stat)
   );

   rtch_div #(.COORD_BITS(CB), .DIR_FRAC_BITS(F), .AW(AW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (tn_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // rejection tests on the sign-normalized sums
   always_comb begin
      hit_ok = (det_ff > AW'(EPS_DET))
             && !un_ff[AW-1] && (un_ff <= det_ff)
             && !vn_ff[AW-1]
             && ((AW+1)'(un_ff) + (AW+1)'(vn_ff) <= (AW+1)'(det_ff))
             && !tn_ff[AW-1] && (tn_ff != '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtch_pkg::ST_IDLE:     if (req_tvalid) state_in = rtch_pkg::ST_MUL_GO;
         rtch_pkg::ST_MUL_GO:   state_in = rtch_pkg::ST_MUL_WAIT;
         rtch_pkg::ST_MUL_WAIT: if (mac_stat.done) state_in = rtch_pkg::ST_ACC;
         rtch_pkg::ST_ACC: begin
            state_in = (step_ff == rtch_pkg::LAST_STEP) ? rtch_pkg::ST_NORM
                                                        : rtch_pkg::ST_MUL_GO;
         end
         rtch_pkg::ST_NORM:     state_in = rtch_pkg::ST_CHECK;
         rtch_pkg::ST_CHECK: begin
            state_in = hit_ok ? rtch_pkg::ST_DIV : rtch_pkg::ST_DONE;
         end
         rtch_pkg::ST_DIV:      if (div_done) state_in = rtch_pkg::ST_DONE;
         rtch_pkg::ST_DONE:     if (rsp_load) state_in = rtch_pkg::ST_IDLE;
         default:               state_in = rtch_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == rtch_pkg::ST_IDLE);
      mac_start  = (state_ff == rtch_pkg::ST_MUL_GO);
      div_start  = (state_ff == rtch_pkg::ST_CHECK) && hit_ok;
      rsp_load   = (state_ff == rtch_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   // datapath
   always_comb begin
      e1_in   = e1_ff;
      e2_in   = e2_ff;
      t_in    = t_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      acc_in  = acc_ff;
      det_in  = det_ff;
      un_in   = un_ff;
      vn_in   = vn_ff;
      tn_in   = tn_ff;
      step_in = step_ff;
      last_in = last_ff;
      dist_in = dist_ff;
      sum     = op.first ? '0 : acc_ff;

      // closest-hit merge
      tri_hit    = (dist_ff != '0);
      upd        = tri_hit && (!best_valid_ff || dist_ff < best_dist_ff);
      near_dist  = upd ? dist_ff : best_dist_ff;
      near_valid = best_valid_ff || upd;
      best_dist_in  = best_dist_ff;
      best_valid_in = best_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         rtch_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < 3; k++) begin
                  e1_in[k] = EW'(vb[k]) - EW'(va[k]);
                  e2_in[k] = EW'(vc[k]) - EW'(va[k]);
                  t_in[k]  = EW'(org_ff[k]) - EW'(va[k]);
               end
               last_in = req_tlast;
               step_in = '0;
            end
         end
         rtch_pkg::ST_ACC: begin
            acc_in  = mac_stat.neg ? (sum - AW'(mac_mag)) : (sum + AW'(mac_mag));
            step_in = step_ff + 1'b1;
            case (op.dest)
               rtch_pkg::DST_P0:  p_in[0] = acc_in[WW-1:0];
               rtch_pkg::DST_P1:  p_in[1] = acc_in[WW-1:0];
               rtch_pkg::DST_P2:  p_in[2] = acc_in[WW-1:0];
               rtch_pkg::DST_Q0:  q_in[0] = acc_in[WW-1:0];
               rtch_pkg::DST_Q1:  q_in[1] = acc_in[WW-1:0];
               rtch_pkg::DST_Q2:  q_in[2] = acc_in[WW-1:0];
               rtch_pkg::DST_DET: det_in  = acc_in;
               rtch_pkg::DST_UN:  un_in   = acc_in;
               rtch_pkg::DST_VN:  vn_in   = acc_in;
               rtch_pkg::DST_TN:  tn_in   = acc_in;
               default: ;
            endcase
         end
         rtch_pkg::ST_NORM: begin
            // when the determinant is negative, negate it and all numerators
            if (det_ff[AW-1]) begin
               det_in = ~det_ff + 1'b1;
               un_in  = ~un_ff + 1'b1;
               vn_in  = ~vn_ff + 1'b1;
               tn_in  = ~tn_ff + 1'b1;
            end
         end
         rtch_pkg::ST_CHECK: begin
            if (!hit_ok) dist_in = '0;
         end
         rtch_pkg::ST_DIV: begin
            if (div_done) dist_in = div_quo;
         end
         rtch_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               rsp_data_in  = OUTW_L'({(near_valid ? near_dist : DW'(0)), near_valid,
                                       dist_ff, tri_hit});
               if (last_ff) begin
                  best_dist_in  = '1;
                  best_valid_in = 1'b0;
               end else begin
                  best_dist_in  = near_dist;
                  best_valid_in = near_valid;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtch_pkg::ST_IDLE;
         best_dist_ff  <= '1;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         best_dist_ff  <= best_dist_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
      end
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      acc_ff      <= acc_in;
      det_ff      <= det_in;
      un_ff       <= un_in;
      vn_ff       <= vn_in;
      tn_ff       <= tn_in;
      last_ff     <= last_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Closest-hit ray/triangle unit: directed rows, then random triangle lists
// under a series of ray settings; all but typed rows are checked against a
// predictor doing the intersection in exact 128-bit integer arithmetic.
module tb;

   localparam int  CLK_HALF   = 4;
   localparam int  CYCLE_CAP  = 6000000;  // watchdog limit, well above the worst case for all beats
   localparam int  DRAIN_WAIT = 1000;     // wait after the last result before the verdict
   localparam int  N_PHASES   = 10;
   localparam int  PHASE_BEATS = 114;
   localparam logic [22:0] DIST_SAT = 23'h7FFFFF;

   typedef struct packed {
      logic [8:0][23:0] v;    // a_x, a_y, a_z, b_x .. c_z; v[0] lowest
      logic             last;
   } tri_type;

   typedef struct packed {
      logic        hit;
      logic [22:0] tri_dist;
      logic        found;
      logic [22:0] near;
      logic        done;
   } hit_type;

   typedef struct packed {
      tri_type shape;
      logic    typed;   // expectation below is fixed, not predicted
      hit_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [215:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = rtch_pkg::CSR_ORG_X;
   logic [23:0] csr_data = '0;

   // ray registers as the unit should hold them
   logic [23:0] ray_org [3];
   logic [15:0] ray_dir [3];
   // running closest hit of the current list
   logic [22:0] near_dist;
   logic        near_valid;

   hit_type pending_hits[$];
   int   mismatches = 0;
   int   cycles = 0;
   bit   quiet = 0;

   ray_triangle_closest_hit_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report(input string what, input logic [22:0] got, input logic [22:0] want);
      mismatches++;
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Moller-Trumbore in exact arithmetic; returns Q15.8 distance, 0 on a miss
   function automatic logic [22:0] ray_hit_distance(input tri_type t);
      logic signed [127:0] d [3];
      logic signed [127:0] e1 [3];
      logic signed [127:0] e2 [3];
      logic signed [127:0] tv [3];
      logic signed [127:0] p [3];
      logic signed [127:0] q [3];
      logic signed [127:0] det, un, vn, tn, quo;
      for (int i = 0; i < 3; i++) begin
         d[i]  = $signed(ray_dir[i]);
         e1[i] = $signed(t.v[3+i]) - $signed(t.v[i]);
         e2[i] = $signed(t.v[6+i]) - $signed(t.v[i]);
         tv[i] = $signed(ray_org[i]) - $signed(t.v[i]);
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = tv[1]*e1[2] - tv[2]*e1[1];
      q[1] = tv[2]*e1[0] - tv[0]*e1[2];
      q[2] = tv[0]*e1[1] - tv[1]*e1[0];
      det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      un  = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
      vn  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      if (det <= rtch_pkg::EPS_DET_DEF) return '0;
      if (un < 0 || un > det) return '0;
      if (vn < 0 || un + vn > det) return '0;
      if (tn <= 0) return '0;
      quo = (tn <<< rtch_pkg::DIR_FRAC_BITS_DEF) / det;
      if (quo > DIST_SAT) return DIST_SAT;
      return quo[22:0];
   endfunction

   function automatic hit_type closest_update(input tri_type t);
      hit_type r;
      logic [22:0] tri_dist;
      tri_dist = ray_hit_distance(t);
      if (tri_dist != 0 && (!near_valid || tri_dist < near_dist)) begin
         near_dist  = tri_dist;
         near_valid = 1;
      end
      r.hit      = (tri_dist != 0);
      r.tri_dist = tri_dist;
      r.found    = near_valid;
      r.near     = near_valid ? near_dist : '0;
      r.done     = t.last;
      if (t.last) begin
         near_dist  = DIST_SAT;
         near_valid = 0;
      end
      return r;
   endfunction

   // result side: random back-pressure, none once quiet
   initial begin
      @(negedge clock);
      forever begin
         rsp_tready <= 1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if (!quiet && $urandom_range(0, 1)) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            report("result beat with nothing outstanding", rsp_tdata[23:1], '0);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_tdata[0] !== want.hit)
               report("tri_hit", 23'(rsp_tdata[0]), 23'(want.hit));
            if (rsp_tdata[23:1] !== want.tri_dist)
               report("tri_distance", rsp_tdata[23:1], want.tri_dist);
            if (rsp_tdata[24] !== want.found)
               report("nearest_found", 23'(rsp_tdata[24]), 23'(want.found));
            if (rsp_tdata[47:25] !== want.near)
               report("nearest_distance", rsp_tdata[47:25], want.near);
            if (rsp_tlast !== want.done)
               report("list_done", 23'(rsp_tlast), 23'(want.done));
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= rtch_pkg::CSR_ORG_Z) ray_org[idx] = val;
      else ray_dir[idx - rtch_pkg::CSR_DIR_X] = val[15:0];
   endtask

   task automatic set_ray(input logic [23:0] ox, oy, oz, input logic [15:0] dx, dy, dz);
      csr_write(rtch_pkg::CSR_ORG_X, ox);
      csr_write(rtch_pkg::CSR_ORG_Y, oy);
      csr_write(rtch_pkg::CSR_ORG_Z, oz);
      csr_write(rtch_pkg::CSR_DIR_X, {{8{dx[15]}}, dx});
      csr_write(rtch_pkg::CSR_DIR_Y, {{8{dy[15]}}, dy});
      csr_write(rtch_pkg::CSR_DIR_Z, {{8{dz[15]}}, dz});
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // one triangle beat; the prediction is made at acceptance
   task automatic send_triangle(input tri_type t, input bit typed, input hit_type want);
      hit_type got_pred;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata  <= t.v;
      req_tlast  <= t.last;
      do @(posedge clock); while (!req_tready);
      got_pred = closest_update(t);
      pending_hits.push_back(typed ? want : got_pred);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [23:0] c24(input longint x);
      return 24'(x);
   endfunction

   function automatic longint spread(input int bits);
      return longint'($urandom_range(0, 2 << bits)) - (longint'(1) << bits);
   endfunction

   // triangle around a point on (or off) the ray, random content
   function automatic tri_type random_triangle();
      tri_type t;
      longint s, p [3], v1 [3], v2 [3], v3 [3];
      int kind, m;
      kind = $urandom_range(0, 99);
      t.last = ($urandom_range(0, 3) == 0);
      if (kind < 15) begin
         for (int i = 0; i < 9; i++) t.v[i] = 24'($urandom);
         return t;
      end
      s = $urandom_range(0, 1 << $urandom_range(1, 20));
      if ($urandom_range(0, 9) == 0) s = -s;
      m = $urandom_range(2, 16);
      for (int i = 0; i < 3; i++) begin
         p[i]  = longint'($signed(ray_org[i])) + ((s * longint'($signed(ray_dir[i]))) >>> 14);
         v1[i] = spread(m);
         v2[i] = spread(m);
         v3[i] = spread(m);
      end
      for (int i = 0; i < 3; i++) begin
         t.v[i]   = c24(p[i] + v1[i]);
         t.v[3+i] = c24(p[i] + v2[i]);
         if (kind < 30)          // degenerate: collinear vertices
            t.v[6+i] = c24(p[i] + 2 * v2[i] - v1[i]);
         else if (kind < 55)     // arbitrary third vertex, often a miss
            t.v[6+i] = c24(p[i] + v3[i]);
         else                    // centroid on the point, a hit when in front
            t.v[6+i] = c24(p[i] - v1[i] - v2[i]);
      end
      return t;
   endfunction

   function automatic row_type mk(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                  input bit last, typed, hit, input int tri_dist,
                                  input bit found, input int near);
      row_type r;
      r.shape.v = {c24(cz), c24(cy), c24(cx), c24(bz), c24(by), c24(bx),
                   c24(az), c24(ay), c24(az == az ? ax : ax)};
      r.shape.last = last;
      r.typed = typed;
      r.want = '{hit: hit, tri_dist: 23'(tri_dist), found: found, near: 23'(near),
                 done: last};
      return r;
   endfunction

   row_type rows [$];

   initial begin
      logic [23:0] ox, oy, oz;
      logic [15:0] dx, dy, dz;
      hit_type none;
      none = '0;
      ray_org = '{24'd0, 24'd0, 24'd0};
      ray_dir = '{16'd16384, 16'd0, 16'd0};
      near_dist = DIST_SAT;
      near_valid = 0;

      // ray from the origin along +x (reset setting)
      // plain hit, closer hit, farther hit closing the list
      rows.push_back(mk(2560,-256,-256, 2560,512,-256, 2560,-256,512, 0,1, 1,2560, 1,2560));
      rows.push_back(mk(1280,-256,-256, 1280,512,-256, 1280,-256,512, 0,1, 1,1280, 1,1280));
      rows.push_back(mk(2560,-256,-256, 2560,512,-256, 2560,-256,512, 1,1, 1,2560, 1,1280));
      // behind the origin
      rows.push_back(mk(-2560,-256,-256, -2560,512,-256, -2560,-256,512, 1,1, 0,0, 0,0));
      // coordinate extremes: all zero, all max, all min are degenerate
      rows.push_back(mk(0,0,0, 0,0,0, 0,0,0, 0,1, 0,0, 0,0));
      rows.push_back(mk(8388607,8388607,8388607, 8388607,8388607,8388607,
                        8388607,8388607,8388607, 0,1, 0,0, 0,0));
      rows.push_back(mk(-8388608,-8388608,-8388608, -8388608,-8388608,-8388608,
                        -8388608,-8388608,-8388608, 1,1, 0,0, 0,0));
      // plane through the origin: zero distance is no hit
      rows.push_back(mk(0,-256,-256, 0,512,-256, 0,-256,512, 0,1, 0,0, 0,0));
      // smallest distance, then hit exactly on a vertex
      rows.push_back(mk(1,-256,-256, 1,512,-256, 1,-256,512, 0,1, 1,1, 1,1));
      rows.push_back(mk(2560,0,0, 2560,256,0, 2560,0,256, 1,1, 1,2560, 1,1));
      // farthest plane the coordinates allow
      rows.push_back(mk(8388607,-256,-256, 8388607,512,-256, 8388607,-256,512,
                        1,1, 1,8388607, 1,8388607));
      // ray in the triangle's plane
      rows.push_back(mk(0,0,0, 2560,0,0, 0,0,2560, 0,1, 0,0, 0,0));
      // a hit on the edge from vertex a to vertex b, a sliver hit, and a far mixed-sign triangle parallel to the ray
      rows.push_back(mk(2560,256,-256, 2560,-256,256, 2560,512,512, 0,0, 0,0, 0,0));
      rows.push_back(mk(640,-1,-1, 640,1,0, 640,0,300, 0,0, 0,0, 0,0));
      rows.push_back(mk(-8388608,8388607,-8388608, 8388607,-8388608,8388607,
                        8388607,8388607,-8388608, 0,0, 0,0, 0,0));
      rows.push_back(mk(3000,-1000,50, 3100,900,-700, 2900,200,900, 1,0, 0,0, 0,0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[i]) send_triangle(rows[i].shape, rows[i].typed, rows[i].want);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_idle();
         ox = 24'($urandom_range(0, 1 << 21)) - 24'(1 << 20);
         oy = 24'($urandom_range(0, 1 << 21)) - 24'(1 << 20);
         oz = 24'($urandom_range(0, 1 << 21)) - 24'(1 << 20);
         {dx, dy, dz} = {16'd0, 16'd0, 16'd0};
         case (ph)
            0: dx = -16'sd16384;
            1: dy = 16'sd16384;
            2: dz = -16'sd16384;
            3: begin ox = 24'h7FFFFF; oy = 24'h7FFFFF; oz = 24'h7FFFFF; dx = -16'sd16384; end
            4: begin ox = 24'h800000; oy = 24'h800000; oz = 24'h800000; dx = 16'sd16384; end
            5: begin dx = 16'sd9459; dy = -16'sd9459; dz = 16'sd9459; end
            6: begin ox = 24'($urandom); oy = 24'($urandom); oz = 24'($urandom);
                  dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom); end
            7: dx = 16'sd1;                      // tiny direction, far distances saturate
            8: begin dx = 16'h8000; dy = 16'h7FFF; dz = 16'hFFFF; end
            default: begin dx = 16'($urandom_range(0, 32768)) - 16'sd16384;
                  dy = 16'($urandom_range(0, 32768)) - 16'sd16384;
                  dz = 16'($urandom_range(0, 32768)) - 16'sd16384; end
         endcase
         set_ray(ox, oy, oz, dx, dy, dz);
         if (ph == N_PHASES - 1) quiet = 1;
         for (int k = 0; k < PHASE_BEATS; k++) send_triangle(random_triangle(), 0, none);
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rtch_pkg.sv
rtl/rtch_mac.sv
rtl/rtch_div.sv
rtl/ray_triangle_closest_hit_unit.sv
test/tb.sv
